>>> hw/rtl/mesh_circuit_route_allocator_macros.svh
// Assertion macros shared by the allocator checker.
// Include guarded; holds macro definitions only.
`ifndef MESH_CIRCUIT_ROUTE_ALLOCATOR_MACROS_SVH
`define MESH_CIRCUIT_ROUTE_ALLOCATOR_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define MCRA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication outside reset.
`define MCRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/mcra_pkg.sv
// Package for the mesh circuit route allocator: sizes, codes, state type.
// No dependencies.
`default_nettype none
package mcra_pkg;
    localparam int MeshXDef = 4;
    localparam int MeshYDef = 4;
    localparam int CoordW   = 2;

    localparam logic [2:0] ST_GRANT     = 3'd0;
    localparam logic [2:0] ST_DST_BUSY  = 3'd1;
    localparam logic [2:0] ST_LINK_BUSY = 3'd2;
    localparam logic [2:0] ST_RELEASED  = 3'd3;
    localparam logic [2:0] ST_NO_CIRC   = 3'd4;
    localparam logic [2:0] ST_SAME      = 3'd5;

    // output port codes
    localparam logic [2:0] P_XP = 3'd0;
    localparam logic [2:0] P_XM = 3'd1;
    localparam logic [2:0] P_YP = 3'd2;
    localparam logic [2:0] P_YM = 3'd3;
    localparam logic [2:0] P_LO = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_APPLY, S_EMIT, S_REFUSE
    } t_state;

    function automatic logic [4:0] en_bit(input logic [2:0] o);
        unique case (o)
            P_XP:    en_bit = 5'd4;
            P_XM:    en_bit = 5'd8;
            P_YP:    en_bit = 5'd2;
            P_YM:    en_bit = 5'd1;
            default: en_bit = 5'd16;
        endcase
    endfunction

    function automatic logic [3:0] sel_shift(input logic [2:0] o);
        unique case (o)
            P_XP:    sel_shift = 4'd4;
            P_XM:    sel_shift = 4'd6;
            P_YP:    sel_shift = 4'd2;
            P_YM:    sel_shift = 4'd0;
            default: sel_shift = 4'd8;
        endcase
    endfunction

    // arrival codes: 0 local,1 from x-,2 from x+,3 from y-,4 from y+
    function automatic logic [1:0] sel_code(input logic [2:0] o, input logic [2:0] a);
        logic [1:0] c;
        c = 2'd0;
        unique case (a)
            3'd1: c = 2'd0;
            3'd2: c = 2'd1;
            3'd3: c = 2'd3;
            3'd4: c = 2'd2;
            default: begin
                unique case (o)
                    P_XP:    c = 2'd1;
                    P_XM:    c = 2'd0;
                    P_YP:    c = 2'd2;
                    P_YM:    c = 2'd3;
                    default: c = 2'd0;
                endcase
            end
        endcase
        if (o == P_XM && a == 3'd1) c = 2'd0;
        if (o == P_YP && a == 3'd4) c = 2'd0;
        if (o == P_YM && a == 3'd3) c = 2'd0;
        sel_code = c;
    endfunction
endpackage
`default_nettype wire

>>> hw/rtl/mesh_circuit_route_allocator.sv
// Top level of the mesh circuit route allocator.
// Depends on mcra_pkg.
//
//  channel | valid     | stall     | payload
//  in      | i_valid   | o_stall   | i_op, i_src_x/y, i_dst_x/y
//  out     | o_valid   | i_stall   | o_status, o_router_x/y, o_enable_bits,
//          |           |           | o_switch_bits, o_channel_open, o_last
//
// A granted request runs a check walk, an update walk and then one emit per
// router along its path; a release skips the check walk; a refusal emits a
// single word.
// One shared step unit walks the path one router per cycle, holding while an emit is stalled.
// Reset clears all tables but the circuit sources at once (16-entry flop tables with valid state).
// A stalled output word holds; no new input word is taken until the last one
// of the current item has been taken.
`default_nettype none
module mesh_circuit_route_allocator #(
    parameter int MESH_X = mcra_pkg::MeshXDef,
    parameter int MESH_Y = mcra_pkg::MeshYDef
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic       i_op,
    input  wire logic [1:0] i_src_x,
    input  wire logic [1:0] i_src_y,
    input  wire logic [1:0] i_dst_x,
    input  wire logic [1:0] i_dst_y,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [2:0]      o_status,
    output logic [1:0]      o_router_x,
    output logic [1:0]      o_router_y,
    output logic [4:0]      o_enable_bits,
    output logic [9:0]      o_switch_bits,
    output logic            o_channel_open,
    output logic            o_last
);
    localparam int NR = MESH_X * MESH_Y;
    localparam int RW = (NR > 1) ? $clog2(NR) : 1;

    mcra_pkg::t_state r_state, n_state;

    logic [3:0] r_link [NR];
    logic [4:0] r_en   [NR];
    logic [9:0] r_sw   [NR];
    logic       r_cv   [NR];
    logic [1:0] r_csx  [NR];
    logic [1:0] r_csy  [NR];
    logic       r_ch   [NR];

    // item registers
    logic       r_rel;
    logic [1:0] r_sx, r_sy, r_dx, r_dy;
    // walker
    logic [1:0] r_x, r_y, n_x, n_y;
    logic [2:0] r_arr, n_arr;
    logic [2:0] r_status;

    // clamp a 2-bit coordinate to the mesh
    function automatic logic [1:0] clampx(input logic [1:0] v);
        clampx = (32'(v) > MESH_X - 1) ? 2'(MESH_X - 1) : v;
    endfunction
    function automatic logic [1:0] clampy(input logic [1:0] v);
        clampy = (32'(v) > MESH_Y - 1) ? 2'(MESH_Y - 1) : v;
    endfunction
    function automatic logic [RW-1:0] ridx(input logic [1:0] x, input logic [1:0] y);
        ridx = RW'(32'(x) + 32'(y) * MESH_X);
    endfunction

    // shared step unit: output port and next position from the walker
    logic [2:0] w_o;
    logic [2:0] w_next_arr;
    logic [1:0] w_nx, w_ny;
    logic [RW-1:0] w_r, w_di, w_si;
    always_comb begin
        w_o = mcra_pkg::P_LO; w_nx = r_x; w_ny = r_y; w_next_arr = 3'd0;
        priority if (r_x < r_dx) begin
            w_o = mcra_pkg::P_XP; w_nx = r_x + 2'd1; w_next_arr = 3'd1;
        end else if (r_x > r_dx) begin
            w_o = mcra_pkg::P_XM; w_nx = r_x - 2'd1; w_next_arr = 3'd2;
        end else if (r_y < r_dy) begin
            w_o = mcra_pkg::P_YP; w_ny = r_y + 2'd1; w_next_arr = 3'd3;
        end else if (r_y > r_dy) begin
            w_o = mcra_pkg::P_YM; w_ny = r_y - 2'd1; w_next_arr = 3'd4;
        end
        w_r  = ridx(r_x, r_y);
        w_di = ridx(r_dx, r_dy);
        w_si = ridx(r_sx, r_sy);
    end

    logic w_in_acc, w_out_acc, w_link_busy;
    assign w_in_acc    = i_valid && !o_stall;
    assign w_out_acc   = o_valid && !i_stall;
    assign w_link_busy = (w_o != mcra_pkg::P_LO) && !r_link[w_r][w_o[1:0]];

    logic [1:0] w_cdx, w_cdy, w_csx, w_csy;
    logic [RW-1:0] w_cdi;
    always_comb begin
        w_cdx = clampx(i_dst_x); w_cdy = clampy(i_dst_y);
        w_csx = clampx(i_src_x); w_csy = clampy(i_src_y);
        w_cdi = ridx(w_cdx, w_cdy);
    end

    // sequencer: next state and walker moves
    always_comb begin
        n_state = r_state; n_x = r_x; n_y = r_y; n_arr = r_arr;
        o_stall = (r_state != mcra_pkg::S_IDLE);
        o_valid = (r_state == mcra_pkg::S_EMIT) || (r_state == mcra_pkg::S_REFUSE);
        unique case (r_state)
            mcra_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_arr = 3'd0;
                    if (i_op) begin
                        n_x = r_csx[w_cdi]; n_y = r_csy[w_cdi];
                        n_state = r_cv[w_cdi] ? mcra_pkg::S_APPLY : mcra_pkg::S_REFUSE;
                    end else begin
                        n_x = w_csx; n_y = w_csy;
                        n_state = (w_csx == w_cdx && w_csy == w_cdy) || r_cv[w_cdi]
                                  ? mcra_pkg::S_REFUSE : mcra_pkg::S_CHECK;
                    end
                end
            end
            mcra_pkg::S_CHECK: begin
                // walk the path, refusing on a busy link; rewind to the source at its end
                if (w_link_busy) begin
                    n_state = mcra_pkg::S_REFUSE;
                end else if (w_o == mcra_pkg::P_LO) begin
                    n_state = mcra_pkg::S_APPLY; n_x = r_sx; n_y = r_sy; n_arr = 3'd0;
                end else begin
                    n_x = w_nx; n_y = w_ny; n_arr = w_next_arr;
                end
            end
            mcra_pkg::S_APPLY: begin
                if (w_o == mcra_pkg::P_LO) begin
                    n_state = mcra_pkg::S_EMIT; n_x = r_sx; n_y = r_sy; n_arr = 3'd0;
                end else begin
                    n_x = w_nx; n_y = w_ny; n_arr = w_next_arr;
                end
            end
            mcra_pkg::S_EMIT: begin
                if (w_out_acc) begin
                    if (w_o == mcra_pkg::P_LO) n_state = mcra_pkg::S_IDLE;
                    else begin
                        n_x = w_nx; n_y = w_ny; n_arr = w_next_arr;
                    end
                end
            end
            mcra_pkg::S_REFUSE: begin
                if (w_out_acc) n_state = mcra_pkg::S_IDLE;
            end
            default: n_state = mcra_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= mcra_pkg::S_IDLE;
        else          r_state <= n_state;
        r_x <= n_x; r_y <= n_y; r_arr <= n_arr;
    end

    // hold the item and pick its status
    always_ff @(posedge i_clk) begin
        if (r_state == mcra_pkg::S_IDLE && w_in_acc) begin
            r_rel <= i_op;
            r_dx  <= w_cdx; r_dy <= w_cdy;
            if (i_op) begin
                r_sx <= r_csx[w_cdi]; r_sy <= r_csy[w_cdi];
                r_status <= r_cv[w_cdi] ? mcra_pkg::ST_RELEASED : mcra_pkg::ST_NO_CIRC;
            end else begin
                r_sx <= w_csx; r_sy <= w_csy;
                if (w_csx == w_cdx && w_csy == w_cdy) r_status <= mcra_pkg::ST_SAME;
                else if (r_cv[w_cdi]) r_status <= mcra_pkg::ST_DST_BUSY;
                else r_status <= mcra_pkg::ST_GRANT;
            end
        end else if (r_state == mcra_pkg::S_CHECK && w_link_busy) begin
            r_status <= mcra_pkg::ST_LINK_BUSY;
        end
    end

    // table updates, one router per cycle
    logic [4:0] w_enb;
    logic [9:0] w_swm, w_swv;
    always_comb begin
        w_enb = mcra_pkg::en_bit(w_o);
        w_swm = 10'(10'd3 << mcra_pkg::sel_shift(w_o));
        w_swv = 10'(10'(mcra_pkg::sel_code(w_o, r_arr)) << mcra_pkg::sel_shift(w_o));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NR; i++) begin
                r_link[i] <= 4'hF; r_en[i] <= '0; r_sw[i] <= '0;
                r_cv[i] <= 1'b0; r_ch[i] <= 1'b0;
            end
        end else if (r_state == mcra_pkg::S_APPLY) begin
            if (r_rel) begin
                r_en[w_r] <= r_en[w_r] & ~w_enb;
                r_sw[w_r] <= r_sw[w_r] & ~w_swm;
                if (w_o != mcra_pkg::P_LO) r_link[w_r][w_o[1:0]] <= 1'b1;
            end else begin
                r_en[w_r] <= r_en[w_r] | w_enb;
                r_sw[w_r] <= r_sw[w_r] | w_swv;
                if (w_o != mcra_pkg::P_LO) r_link[w_r][w_o[1:0]] <= 1'b0;
            end
            if (w_o == mcra_pkg::P_LO) begin
                r_cv[w_di] <= !r_rel;
                r_ch[w_si] <= !r_rel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == mcra_pkg::S_APPLY && w_o == mcra_pkg::P_LO && !r_rel) begin
            r_csx[w_di] <= r_sx; r_csy[w_di] <= r_sy;
        end
    end

    // output word: walker position drives the router fields
    logic w_emit;
    assign w_emit = (r_state == mcra_pkg::S_EMIT);
    always_comb begin
        o_status       = r_status;
        o_router_x     = w_emit ? r_x : 2'd0;
        o_router_y     = w_emit ? r_y : 2'd0;
        o_enable_bits  = w_emit ? r_en[w_r] : 5'd0;
        o_switch_bits  = w_emit ? r_sw[w_r] : 10'd0;
        o_channel_open = w_emit ? r_ch[w_si] : 1'b0;
        o_last         = w_emit ? (w_o == mcra_pkg::P_LO) : 1'b1;
    end
endmodule
`default_nettype wire

>>> hw/rtl/mcra_checker.sv
// Port-level checker for the allocator, bound to the top level.
// Depends on mesh_circuit_route_allocator_macros.svh and mcra_pkg.
`default_nettype none
`include "mesh_circuit_route_allocator_macros.svh"
module mcra_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_stall,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [2:0] o_status,
    input wire logic       o_last
);
    logic w_refusal;
    assign w_refusal = o_valid && (o_status != mcra_pkg::ST_GRANT)
                       && (o_status != mcra_pkg::ST_RELEASED);

    // refusals are a single word
    `MCRA_ASSERT_IMP(a_refuse_last, i_clk, i_rst_n, w_refusal, o_last)
    // input is not taken while a word is shown
    `MCRA_ASSERT_IMP(a_busy_out, i_clk, i_rst_n, o_valid, o_stall)
    // a taken input word makes the block busy
    `MCRA_ASSERT_NEXT(a_take_busy, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    // a stalled word holds
    `MCRA_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_status))
    // after the last word is taken the block is ready
    `MCRA_ASSERT_NEXT(a_ready, i_clk, i_rst_n, o_valid && !i_stall && o_last, !o_stall)
endmodule

bind mesh_circuit_route_allocator mcra_checker u_mcra_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_status(o_status), .o_last(o_last)
);
`default_nettype wire

>>> test/mesh_circuit_route_allocator_checker.sv
// Checker for the mesh circuit route allocator: tracks the circuit tables,
// predicts every output word and compares it. Depends on mcra_pkg.
`default_nettype none
module mesh_circuit_route_allocator_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic       i_in_stall,
    input  wire logic       i_op,
    input  wire logic [1:0] i_src_x,
    input  wire logic [1:0] i_src_y,
    input  wire logic [1:0] i_dst_x,
    input  wire logic [1:0] i_dst_y,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_stall,
    input  wire logic [2:0] i_status,
    input  wire logic [1:0] i_router_x,
    input  wire logic [1:0] i_router_y,
    input  wire logic [4:0] i_enable_bits,
    input  wire logic [9:0] i_switch_bits,
    input  wire logic       i_channel_open,
    input  wire logic       i_last,
    output int              o_fail_count,
    output int              o_pending,
    output int              o_grants,
    output int              o_releases
);
    typedef struct packed {
        logic [2:0] status;
        logic [1:0] rx;
        logic [1:0] ry;
        logic [4:0] en;
        logic [9:0] sw;
        logic       ch;
        logic       last;
    } t_route_word;

    t_route_word route_words_due[$];
    logic [3:0]  link_free_tbl [16];
    logic [4:0]  enables_tbl   [16];
    logic [9:0]  switches_tbl  [16];
    logic        circ_valid    [16];
    logic [1:0]  circ_sx       [16];
    logic [1:0]  circ_sy       [16];
    logic        chan_open     [16];

    assign o_pending = route_words_due.size();

    function automatic logic [4:0] port_enable(input logic [2:0] o);
        unique case (o)
            mcra_pkg::P_XP: return 5'd4;
            mcra_pkg::P_XM: return 5'd8;
            mcra_pkg::P_YP: return 5'd2;
            mcra_pkg::P_YM: return 5'd1;
            default:        return 5'd16;
        endcase
    endfunction

    function automatic int port_shift(input logic [2:0] o);
        unique case (o)
            mcra_pkg::P_XP: return 4;
            mcra_pkg::P_XM: return 6;
            mcra_pkg::P_YP: return 2;
            mcra_pkg::P_YM: return 0;
            default:        return 8;
        endcase
    endfunction

    // arrival: 0 local, 1 from x-, 2 from x+, 3 from y-, 4 from y+
    function automatic logic [1:0] select_for(input logic [2:0] o, input int a);
        unique case (a)
            1: return 2'd0;
            2: return (o == mcra_pkg::P_XP) ? 2'd0 : 2'd1;
            3: return (o == mcra_pkg::P_YM) ? 2'd0 : 2'd3;
            4: return (o == mcra_pkg::P_YP) ? 2'd0 : 2'd2;
            default: begin
                unique case (o)
                    mcra_pkg::P_XP: return 2'd1;
                    mcra_pkg::P_YP: return 2'd2;
                    mcra_pkg::P_YM: return 2'd3;
                    default:        return 2'd0;
                endcase
            end
        endcase
    endfunction

    // append one expected word at the tail of the queue
    task automatic queue_word(input t_route_word w);
        route_words_due = {route_words_due, w};
    endtask

    task automatic push_refusal(input logic [2:0] st);
        t_route_word w;
        w = '0;
        w.status = st;
        w.last = 1'b1;
        queue_word(w);
    endtask

    // Walk the X-then-Y path, updating tables and queueing one word per router, or queue a single refusal word.
    task automatic allocate_route(input logic rel, input logic [1:0] sx_in,
                                  input logic [1:0] sy_in, input logic [1:0] dx,
                                  input logic [1:0] dy);
        int px[7], py[7], pa[7];
        logic [2:0] po[7];
        int n, x, y, arr, r, di, si, sh;
        logic [1:0] sx, sy;
        t_route_word w;
        di = dx + dy * 4;
        if (rel) begin
            if (!circ_valid[di]) begin
                push_refusal(mcra_pkg::ST_NO_CIRC);
                return;
            end
            sx = circ_sx[di];
            sy = circ_sy[di];
        end else begin
            sx = sx_in;
            sy = sy_in;
            if (sx == dx && sy == dy) begin
                push_refusal(mcra_pkg::ST_SAME);
                return;
            end
            if (circ_valid[di]) begin
                push_refusal(mcra_pkg::ST_DST_BUSY);
                return;
            end
        end
        n = 0;
        x = sx;
        y = sy;
        arr = 0;
        while (n < 7) begin
            px[n] = x;
            py[n] = y;
            pa[n] = arr;
            if (x < dx) begin po[n] = mcra_pkg::P_XP; x++; arr = 1; end
            else if (x > dx) begin po[n] = mcra_pkg::P_XM; x--; arr = 2; end
            else if (y < dy) begin po[n] = mcra_pkg::P_YP; y++; arr = 3; end
            else if (y > dy) begin po[n] = mcra_pkg::P_YM; y--; arr = 4; end
            else po[n] = mcra_pkg::P_LO;
            n++;
            if (po[n-1] == mcra_pkg::P_LO) break;
        end
        if (!rel) begin
            for (int k = 0; k < n; k++) begin
                r = px[k] + py[k] * 4;
                if (po[k] != mcra_pkg::P_LO && !link_free_tbl[r][po[k]]) begin
                    push_refusal(mcra_pkg::ST_LINK_BUSY);
                    return;
                end
            end
        end
        for (int k = 0; k < n; k++) begin
            r = px[k] + py[k] * 4;
            sh = port_shift(po[k]);
            if (rel) begin
                enables_tbl[r] &= ~port_enable(po[k]);
                switches_tbl[r] &= ~(10'd3 << sh);
                if (po[k] != mcra_pkg::P_LO) link_free_tbl[r][po[k]] = 1'b1;
            end else begin
                enables_tbl[r] |= port_enable(po[k]);
                switches_tbl[r] |= 10'(select_for(po[k], pa[k])) << sh;
                if (po[k] != mcra_pkg::P_LO) link_free_tbl[r][po[k]] = 1'b0;
            end
        end
        si = sx + sy * 4;
        circ_valid[di] = !rel;
        circ_sx[di] = sx;
        circ_sy[di] = sy;
        chan_open[si] = !rel;
        if (rel) o_releases++;
        else o_grants++;
        for (int k = 0; k < n; k++) begin
            r = px[k] + py[k] * 4;
            w.status = rel ? mcra_pkg::ST_RELEASED : mcra_pkg::ST_GRANT;
            w.rx = 2'(px[k]);
            w.ry = 2'(py[k]);
            w.en = enables_tbl[r];
            w.sw = switches_tbl[r];
            w.ch = chan_open[si];
            w.last = (k == n - 1);
            queue_word(w);
        end
    endtask

    always @(posedge i_clk) begin
        t_route_word got, want;
        if (!i_rst_n) begin
            route_words_due.delete();
            for (int i = 0; i < 16; i++) begin
                link_free_tbl[i] = 4'hf;
                enables_tbl[i] = '0;
                switches_tbl[i] = '0;
                circ_valid[i] = 1'b0;
                circ_sx[i] = '0;
                circ_sy[i] = '0;
                chan_open[i] = 1'b0;
            end
            o_fail_count = 0;
            o_grants = 0;
            o_releases = 0;
        end else begin
            // Compare outputs before queueing new words: the block never
            // emits a word for an item in the same edge it accepts it.
            if (i_out_valid && !i_out_stall) begin
                got = {i_status, i_router_x, i_router_y, i_enable_bits,
                       i_switch_bits, i_channel_open, i_last};
                if (route_words_due.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected output word %h", got);
                    o_fail_count++;
                end else begin
                    want = route_words_due.pop_front();
                    if (got !== want) begin
                        if (o_fail_count < 10) begin
                            $display("mismatch: want st=%0d r=(%0d,%0d) en=%h sw=%h ch=%b l=%b",
                                     want.status, want.rx, want.ry, want.en, want.sw,
                                     want.ch, want.last);
                            $display("           got st=%0d r=(%0d,%0d) en=%h sw=%h ch=%b l=%b",
                                     got.status, got.rx, got.ry, got.en, got.sw,
                                     got.ch, got.last);
                        end
                        o_fail_count++;
                    end
                end
            end
            if (i_valid && !i_in_stall)
                allocate_route(i_op, i_src_x, i_src_y, i_dst_x, i_dst_y);
        end
    end
endmodule
`default_nettype wire

>>> test/mesh_circuit_route_allocator_tb.sv
// Testbench top for the mesh circuit route allocator: drives request and
// release words, stalls the output, and reports the verdict.
// Depends on mesh_circuit_route_allocator_checker.
`default_nettype none
module mesh_circuit_route_allocator_tb;
    localparam int WatchdogLimit = 20000;
    localparam int RandomItems   = 260;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       op;
    logic [1:0] src_x, src_y, dst_x, dst_y;
    logic       out_valid;
    logic       out_stall;
    logic [2:0] status;
    logic [1:0] router_x, router_y;
    logic [4:0] enable_bits;
    logic [9:0] switch_bits;
    logic       channel_open;
    logic       last;
    int         fail_count, pending, grants, releases;
    int         idle_cycles;
    int         words_sent;
    bit         hold_off;

    mesh_circuit_route_allocator i_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_op(op), .i_src_x(src_x), .i_src_y(src_y), .i_dst_x(dst_x),
        .i_dst_y(dst_y), .o_valid(out_valid), .i_stall(out_stall),
        .o_status(status), .o_router_x(router_x), .o_router_y(router_y),
        .o_enable_bits(enable_bits), .o_switch_bits(switch_bits),
        .o_channel_open(channel_open), .o_last(last)
    );

    mesh_circuit_route_allocator_checker i_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_in_stall(in_stall),
        .i_op(op), .i_src_x(src_x), .i_src_y(src_y), .i_dst_x(dst_x),
        .i_dst_y(dst_y), .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_status(status), .i_router_x(router_x), .i_router_y(router_y),
        .i_enable_bits(enable_bits), .i_switch_bits(switch_bits),
        .i_channel_open(channel_open), .i_last(last),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_grants(grants), .o_releases(releases)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: count cycles with no accepted word on either side.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: stall on its own pattern; one long hold-off lets the block
    // fill and push back on the sender.
    initial begin
        int mode;
        out_stall = 1'b0;
        @(posedge clk iff rst_n);
        forever begin
            if (hold_off) begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(4, 40)) begin
                unique case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 1) == 0);
                    default: out_stall <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // Offer one word and hold it until the block takes it.
    task automatic send_word(input logic o, input logic [1:0] sx, input logic [1:0] sy,
                             input logic [1:0] dx, input logic [1:0] dy);
        in_valid <= 1'b1;
        op <= o;
        src_x <= sx;
        src_y <= sy;
        dst_x <= dx;
        dst_y <= dy;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        words_sent++;
    endtask

    task automatic pause_sender();
        if ($urandom_range(0, 2) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    endtask

    initial begin
        int burst;
        logic [1:0] a, b, c, d;
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = 1'b0;
        src_x = '0;
        src_y = '0;
        dst_x = '0;
        dst_y = '0;
        idle_cycles = 0;
        words_sent = 0;
        hold_off = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: corner-to-corner paths, every refusal, release of each.
        send_word(1'b1, 2'd0, 2'd0, 2'd3, 2'd3);  // release with no circuit
        send_word(1'b0, 2'd2, 2'd1, 2'd2, 2'd1);  // source equals destination
        send_word(1'b0, 2'd0, 2'd0, 2'd3, 2'd3);  // longest path x+ then y+
        send_word(1'b0, 2'd1, 2'd2, 2'd3, 2'd3);  // destination busy
        send_word(1'b0, 2'd1, 2'd0, 2'd3, 2'd2);  // shares link, busy
        send_word(1'b0, 2'd3, 2'd3, 2'd0, 2'd0);  // x- then y-
        send_word(1'b0, 2'd3, 2'd0, 2'd0, 2'd3);  // x- then y+
        send_word(1'b0, 2'd0, 2'd3, 2'd3, 2'd0);  // x+ then y-
        send_word(1'b0, 2'd0, 2'd0, 2'd0, 2'd2);  // pure y+, same source
        send_word(1'b0, 2'd2, 2'd1, 2'd1, 2'd1);  // pure x-
        send_word(1'b1, 2'd3, 2'd3, 2'd3, 2'd3);  // src fields ignored
        send_word(1'b1, 2'd0, 2'd0, 2'd0, 2'd0);
        send_word(1'b1, 2'd0, 2'd0, 2'd0, 2'd3);
        send_word(1'b1, 2'd0, 2'd0, 2'd3, 2'd0);
        send_word(1'b1, 2'd0, 2'd0, 2'd0, 2'd2);
        send_word(1'b1, 2'd0, 2'd0, 2'd1, 2'd1);
        send_word(1'b1, 2'd0, 2'd0, 2'd1, 2'd1);  // second release, no circuit

        // Random: mostly requests, with releases of random destinations.
        hold_off = 1'b1;
        while (words_sent < RandomItems + 17) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
                a = 2'($urandom);
                b = 2'($urandom);
                c = 2'($urandom);
                d = 2'($urandom);
                send_word(($urandom_range(0, 99) < 40), a, b, c, d);
            end
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 15)) @(posedge clk);
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        $display("run: %0d words sent, %0d circuits granted, %0d released",
                 words_sent, grants, releases);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire

>>> mesh_circuit_route_allocator.f
+incdir+hw/rtl
hw/rtl/mcra_pkg.sv
hw/rtl/mesh_circuit_route_allocator.sv
hw/rtl/mcra_checker.sv
test/mesh_circuit_route_allocator_checker.sv
test/mesh_circuit_route_allocator_tb.sv
